// ----- hdl/interleaved_vram_pixel_decoder_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the interleaved video memory pixel decoder
// Shared wrappers so every checked module reports the same way.
// ---------------------------------------------------------------------------
`ifndef INTERLEAVED_VRAM_PIXEL_DECODER_TOP_MACROS_SVH
`define INTERLEAVED_VRAM_PIXEL_DECODER_TOP_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define IVPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define IVPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ivpd_pkg.sv -----
// ---------------------------------------------------------------------------
// ivpd_pkg
// Shared types, constants and palette for the pixel decoder.
// ---------------------------------------------------------------------------
package ivpd_pkg;

   // field widths
   localparam int ROW_W   = 8;
   localparam int COL_W   = 7;
   localparam int ADDR_W  = 14;
   localparam int X_W     = 10;
   localparam int PEN_W   = 4;
   localparam int LEVEL_W = 8;
   localparam int BYTE_W  = 8;
   localparam int PIX_W   = 3;

   // geometry defaults
   localparam int SCREEN_ROWS_DEF   = 200;
   localparam int BYTES_PER_ROW_DEF = 80;
   localparam int MEMORY_BYTES      = 16384;
   localparam int BANK_SHIFT        = 11;   // 0x0800 bytes per bank

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;

   // levels
   localparam logic [LEVEL_W-1:0] LVL_OFF  = 8'd0;
   localparam logic [LEVEL_W-1:0] LVL_HALF = 8'd128;
   localparam logic [LEVEL_W-1:0] LVL_FULL = 8'd255;

   // register codes
   localparam logic [1:0] CSR_MODE_RESET = 2'd1;

   typedef enum logic [1:0] {
      MODE_PEN16 = 2'd0,
      MODE_PEN4  = 2'd1,
      MODE_PEN2  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } colour_type;

   // one decoded byte waiting for the back end
   typedef struct packed {
      logic [BYTE_W-1:0] screen_byte;
      mode_type          mode;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [ADDR_W-1:0] address;
      logic              frame_end;
   } job_type;

   // index of the final pixel of a byte
   function automatic logic [PIX_W-1:0] mode_last_pixel(mode_type mode);
      logic [PIX_W-1:0] last;
      unique case (mode)
         MODE_PEN16: last = 3'd1;
         MODE_PEN4:  last = 3'd3;
         default:    last = 3'd7;
      endcase
      return last;
   endfunction

   // log2 of pixels per byte
   function automatic logic [1:0] mode_shift(mode_type mode);
      logic [1:0] sh;
      unique case (mode)
         MODE_PEN16: sh = 2'd1;
         MODE_PEN4:  sh = 2'd2;
         default:    sh = 2'd3;
      endcase
      return sh;
   endfunction

   // fixed palettes
   function automatic colour_type palette_lookup(mode_type mode, logic [PEN_W-1:0] pen);
      colour_type c;
      c = '{red: LVL_OFF, green: LVL_OFF, blue: LVL_OFF};
      unique case (mode)
         MODE_PEN16: begin
            case (pen)
               4'd0:    c = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
               4'd1:    c = '{LVL_OFF,  LVL_OFF,  LVL_HALF};
               4'd2:    c = '{LVL_OFF,  LVL_OFF,  LVL_FULL};
               4'd3:    c = '{LVL_HALF, LVL_OFF,  LVL_OFF};
               4'd4:    c = '{LVL_HALF, LVL_OFF,  LVL_HALF};
               4'd5:    c = '{LVL_HALF, LVL_OFF,  LVL_FULL};
               4'd6:    c = '{LVL_FULL, LVL_OFF,  LVL_OFF};
               4'd7:    c = '{LVL_FULL, LVL_OFF,  LVL_HALF};
               4'd8:    c = '{LVL_FULL, LVL_OFF,  LVL_FULL};
               4'd9:    c = '{LVL_OFF,  LVL_HALF, LVL_OFF};
               4'd10:   c = '{LVL_OFF,  LVL_HALF, LVL_HALF};
               4'd11:   c = '{LVL_OFF,  LVL_HALF, LVL_FULL};
               4'd12:   c = '{LVL_HALF, LVL_HALF, LVL_OFF};
               4'd13:   c = '{LVL_HALF, LVL_HALF, LVL_HALF};
               4'd14:   c = '{LVL_HALF, LVL_HALF, LVL_FULL};
               default: c = '{LVL_OFF,  LVL_FULL, LVL_OFF};
            endcase
         end
         MODE_PEN4: begin
            // black, yellow, cyan, white
            c.red   = (pen == 4'd1 || pen == 4'd3) ? LVL_FULL : LVL_OFF;
            c.green = (pen != 4'd0) ? LVL_FULL : LVL_OFF;
            c.blue  = (pen >= 4'd2) ? LVL_FULL : LVL_OFF;
         end
         default: begin
            c.red   = (pen != 4'd0) ? LVL_FULL : LVL_OFF;
            c.green = c.red;
            c.blue  = c.red;
         end
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/ivpd_front.sv -----
// ---------------------------------------------------------------------------
// ivpd_front
// Accepts screen words, tracks raster position and builds decode jobs.
// ---------------------------------------------------------------------------
module ivpd_front #(
   parameter int SCREEN_ROWS   = ivpd_pkg::SCREEN_ROWS_DEF,
   parameter int BYTES_PER_ROW = ivpd_pkg::BYTES_PER_ROW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ivpd_pkg::BYTE_W-1:0] req_screen_byte,
   output logic                        push_valid,
   input  logic                        push_ready,
   output ivpd_pkg::job_type           push_job
);
   import ivpd_pkg::*;

   localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(BYTES_PER_ROW - 1);
   localparam logic [ADDR_W-1:0] GROUP_STRIDE = ADDR_W'(BYTES_PER_ROW);

   logic [1:0]        mode_ff, mode_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              accept;
   mode_type          mode_eff;
   logic [ADDR_W-1:0] bank_base;
   logic [ADDR_W-1:0] group_offset;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // mode register; code 3 decodes as the 8-pixel mode
   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
      if (mode_ff == MODE_PEN16) begin
         mode_eff = MODE_PEN16;
      end else if (mode_ff == MODE_PEN4) begin
         mode_eff = MODE_PEN4;
      end else begin
         mode_eff = MODE_PEN2;
      end
   end

   // interleaved address, wraps at the memory size
   assign bank_base    = ADDR_W'(row_ff[2:0]) << BANK_SHIFT;
   assign group_offset = ADDR_W'(row_ff[ROW_W-1:3]) * GROUP_STRIDE;

   always_comb begin
      push_job.screen_byte = req_screen_byte;
      push_job.mode        = mode_eff;
      push_job.column      = col_ff;
      push_job.row         = row_ff;
      push_job.address     = bank_base + group_offset + ADDR_W'(col_ff);
      push_job.frame_end   = (row_ff == LAST_ROW) && (col_ff == LAST_COL);
   end

   // raster counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= CSR_MODE_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ----- hdl/ivpd_queue.sv -----
// ---------------------------------------------------------------------------
// ivpd_queue
// Short job queue between the front and back ends.
// ---------------------------------------------------------------------------
`include "interleaved_vram_pixel_decoder_top_macros.svh"

module ivpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ivpd_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ivpd_pkg::job_type pop_job
);
   import ivpd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   job_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   `IVPD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "queue count overflow")
   `IVPD_ASSERT_NEXT(a_push_counts, push && !pop, count_ff == $past(count_ff) + 1'b1, "push lost")
   `IVPD_ASSERT_NEXT(a_pop_counts, pop && !push, count_ff == $past(count_ff) - 1'b1, "pop lost")

endmodule

// ----- hdl/ivpd_back.sv -----
// ---------------------------------------------------------------------------
// ivpd_back
// Walks each job's pixels into the output register, one per stall-free cycle.
// ---------------------------------------------------------------------------
`include "interleaved_vram_pixel_decoder_top_macros.svh"

module ivpd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  ivpd_pkg::job_type            job,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ivpd_pkg::X_W-1:0]     rsp_pixel_x,
   output logic [ivpd_pkg::ROW_W-1:0]   rsp_pixel_row,
   output logic [ivpd_pkg::ADDR_W-1:0]  rsp_source_address,
   output logic [ivpd_pkg::PEN_W-1:0]   rsp_pen_index,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_red,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_green,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_blue,
   output logic                         rsp_last_of_byte,
   output logic                         rsp_last_of_frame
);
   import ivpd_pkg::*;

   // current job
   logic              cur_valid_ff, cur_valid_in;
   job_type           cur_ff, cur_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;

   // output word
   logic              out_valid_ff, out_valid_in;
   logic [X_W-1:0]    x_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PEN_W-1:0]  pen_ff;
   colour_type        colour_ff;
   logic              last_byte_ff;
   logic              last_frame_ff;

   logic              out_load;
   logic              advance;
   logic              last_pix;
   logic [PEN_W-1:0]  pen;
   logic [1:0]        s2;
   logic [PIX_W-1:0]  s4;
   logic [X_W-1:0]    x_val;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign advance   = cur_valid_ff && out_load;
   assign last_pix  = (pix_ff == mode_last_pixel(cur_ff.mode));
   assign job_ready = !cur_valid_ff || (advance && last_pix);

   // pen unpack, bits interleaved per mode
   always_comb begin
      s2  = {1'b0, pix_ff[0]};
      s4  = {1'b0, pix_ff[1:0]};
      pen = '0;
      unique case (cur_ff.mode)
         MODE_PEN16: begin
            pen = {cur_ff.screen_byte[3'd1 - 3'(s2)],
                   cur_ff.screen_byte[3'd5 - 3'(s2)],
                   cur_ff.screen_byte[3'd3 - 3'(s2)],
                   cur_ff.screen_byte[3'd7 - 3'(s2)]};
         end
         MODE_PEN4: begin
            pen = {2'b00, cur_ff.screen_byte[3'd7 - s4], cur_ff.screen_byte[3'd3 - s4]};
         end
         default: begin
            pen = {3'b000, cur_ff.screen_byte[3'd7 - pix_ff]};
         end
      endcase
   end

   assign x_val = (X_W'(cur_ff.column) << mode_shift(cur_ff.mode)) + X_W'(pix_ff);

   // job and pixel sequencing
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      pix_in       = pix_ff;
      if (job_ready) begin
         cur_valid_in = job_valid;
         cur_in       = job;
         pix_in       = '0;
      end else if (advance) begin
         pix_in = pix_ff + 1'b1;
      end
      out_valid_in = out_load ? cur_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pix_ff <= pix_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff          <= x_val;
         row_ff        <= cur_ff.row;
         addr_ff       <= cur_ff.address;
         pen_ff        <= pen;
         colour_ff     <= palette_lookup(cur_ff.mode, pen);
         last_byte_ff  <= last_pix;
         last_frame_ff <= last_pix && cur_ff.frame_end;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pixel_x        = x_ff;
   assign rsp_pixel_row      = row_ff;
   assign rsp_source_address = addr_ff;
   assign rsp_pen_index      = pen_ff;
   assign rsp_red            = colour_ff.red;
   assign rsp_green          = colour_ff.green;
   assign rsp_blue           = colour_ff.blue;
   assign rsp_last_of_byte   = last_byte_ff;
   assign rsp_last_of_frame  = last_frame_ff;

   `IVPD_ASSERT_NOW(a_frame_on_byte, out_valid_ff && last_frame_ff, last_byte_ff, "frame end off byte end")
   `IVPD_ASSERT_NOW(a_pix_range, cur_valid_ff, pix_ff <= mode_last_pixel(cur_ff.mode), "pixel index past byte")
   `IVPD_ASSERT_NEXT(a_job_kept, advance && !last_pix, cur_valid_ff, "job dropped mid byte")

endmodule

// ----- hdl/interleaved_vram_pixel_decoder_top.sv -----
// A word accepted by the front end passes the job queue, the current-job register
// and the output register. One pixel per cycle while not stalled; a word gives
// 2, 4 or 8 pixels (mode 0, 1, 2/3). Up to four words queue while pixels stall.
// Reset: synchronous, active high; clears row and column to 0, mode to 1,
// and empties the job queue and output register.
// ---------------------------------------------------------------------------
// interleaved_vram_pixel_decoder_top
// Decodes raster-ordered screen words into addressed, colored pixels.
// ---------------------------------------------------------------------------
module interleaved_vram_pixel_decoder_top #(
   parameter int SCREEN_ROWS   = ivpd_pkg::SCREEN_ROWS_DEF,
   parameter int BYTES_PER_ROW = ivpd_pkg::BYTES_PER_ROW_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ivpd_pkg::BYTE_W-1:0]  req_screen_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ivpd_pkg::X_W-1:0]     rsp_pixel_x,
   output logic [ivpd_pkg::ROW_W-1:0]   rsp_pixel_row,
   output logic [ivpd_pkg::ADDR_W-1:0]  rsp_source_address,
   output logic [ivpd_pkg::PEN_W-1:0]   rsp_pen_index,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_red,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_green,
   output logic [ivpd_pkg::LEVEL_W-1:0] rsp_blue,
   output logic                         rsp_last_of_byte,
   output logic                         rsp_last_of_frame
);
   import ivpd_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   // front end: counters, address, mode
   ivpd_front #(
      .SCREEN_ROWS   (SCREEN_ROWS),
      .BYTES_PER_ROW (BYTES_PER_ROW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_screen_byte  (req_screen_byte),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   // job queue
   ivpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // back end: pixel walk and palette
   ivpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (pop_valid),
      .job_ready          (pop_ready),
      .job                (pop_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_source_address (rsp_source_address),
      .rsp_pen_index      (rsp_pen_index),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_last_of_byte   (rsp_last_of_byte),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel decoder testbench
// Feeds screen words through the interleaved pixel decoder in every display
// mode. Idle gaps are applied on both the sender and the receiver side.
// A scoreboard class tracks the raster position and predicts each pixel.
// It computes the pixel's address, pen and color and checks every output
// field in order. A long receiver hold-off fills the block, and the sender
// pauses for a full drain before each mode change.
// ---------------------------------------------------------------------------
module testbench;
   import ivpd_pkg::*;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          MAX_REPORTS     = 10;
   localparam int          DRAIN_PAD       = 6;
   localparam int          RSP_HOLD_CYCLES = 300;
   // mode code 3 decodes like the 8-pixel mode
   localparam logic [1:0]  MODE_PEN2_ALIAS = 2'd3;
   localparam logic [7:0]  LEVELS [3]      = '{LVL_OFF, LVL_HALF, LVL_FULL};

   typedef struct packed {
      logic [X_W-1:0]     x;
      logic [ROW_W-1:0]   row;
      logic [ADDR_W-1:0]  address;
      logic [PEN_W-1:0]   pen;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic               last_byte;
      logic               last_frame;
   } pixel_type;

   // predicts decoded pixels and checks them in arrival order
   class pixel_scoreboard;
      pixel_type        pixels_due[$];
      logic [1:0]       mode_reg;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      int               mismatches;

      function new();
         mode_reg   = CSR_MODE_RESET;
         row        = '0;
         col        = '0;
         mismatches = 0;
      endfunction

      function void set_mode(logic [1:0] value);
         mode_reg = value;
      endfunction

      function int pending();
         return pixels_due.size();
      endfunction

      function int failures();
         return mismatches + pixels_due.size();
      endfunction

      function string image(pixel_type p);
         return $sformatf("x=%0d row=%0d addr=%0d pen=%0d rgb=%0d/%0d/%0d lb=%0b lf=%0b",
                          p.x, p.row, p.address, p.pen, p.red, p.green, p.blue,
                          p.last_byte, p.last_frame);
      endfunction

      // one accepted screen word: queue its pixels, then advance the raster
      function void note_word(logic [7:0] b);
         mode_type  eff;
         int        count;
         int        s;
         int        m;
         int        addr;
         logic      frame_end;
         pixel_type p;
         case (mode_type'(mode_reg))
            MODE_PEN16: eff = MODE_PEN16;
            MODE_PEN4:  eff = MODE_PEN4;
            default:    eff = MODE_PEN2;
         endcase
         count     = (eff == MODE_PEN16) ? 2 : (eff == MODE_PEN4) ? 4 : 8;
         addr      = row[2:0] * 2048 + (row / 8) * BYTES_PER_ROW_DEF + col;
         frame_end = (row == SCREEN_ROWS_DEF - 1) && (col == BYTES_PER_ROW_DEF - 1);
         for (int i = 0; i < count; i++) begin
            p.x       = X_W'(col * count + i);
            p.row     = row;
            p.address = ADDR_W'(addr);
            // pen bits are spread across the word
            case (eff)
               MODE_PEN16: begin
                  s     = i & 1;
                  p.pen = {b[1 - s], b[5 - s], b[3 - s], b[7 - s]};
               end
               MODE_PEN4: begin
                  s     = i & 3;
                  p.pen = {2'b00, b[7 - s], b[3 - s]};
               end
               default: p.pen = {3'b000, b[7 - i]};
            endcase
            // fixed palettes
            case (eff)
               MODE_PEN16: begin
                  if (p.pen <= 4'd8) begin
                     p.red   = LEVELS[p.pen / 3];
                     p.green = LVL_OFF;
                     p.blue  = LEVELS[p.pen % 3];
                  end else if (p.pen <= 4'd14) begin
                     m       = p.pen - 9;
                     p.red   = LEVELS[m / 3];
                     p.green = LVL_HALF;
                     p.blue  = LEVELS[m % 3];
                  end else begin
                     p.red   = LVL_OFF;
                     p.green = LVL_FULL;
                     p.blue  = LVL_OFF;
                  end
               end
               MODE_PEN4: begin
                  p.red   = (p.pen == 4'd1 || p.pen == 4'd3) ? LVL_FULL : LVL_OFF;
                  p.green = (p.pen != 4'd0) ? LVL_FULL : LVL_OFF;
                  p.blue  = (p.pen >= 4'd2) ? LVL_FULL : LVL_OFF;
               end
               default: begin
                  p.red   = (p.pen != 4'd0) ? LVL_FULL : LVL_OFF;
                  p.green = p.red;
                  p.blue  = p.red;
               end
            endcase
            p.last_byte  = (i == count - 1);
            p.last_frame = p.last_byte && frame_end;
            pixels_due   = {pixels_due, p};
         end
         // raster advance with column and row wrap
         if (col + 1 >= BYTES_PER_ROW_DEF) begin
            col = '0;
            row = (row + 1 >= SCREEN_ROWS_DEF) ? '0 : row + 1'b1;
         end else begin
            col = col + 1'b1;
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         string     diff;
         if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected pixel: %s", $realtime, image(got));
            return;
         end
         want = pixels_due.pop_front();
         diff = "";
         if (got.x !== want.x)                   diff = {diff, " pixel_x"};
         if (got.row !== want.row)               diff = {diff, " pixel_row"};
         if (got.address !== want.address)       diff = {diff, " source_address"};
         if (got.pen !== want.pen)               diff = {diff, " pen_index"};
         if (got.red !== want.red)               diff = {diff, " red"};
         if (got.green !== want.green)           diff = {diff, " green"};
         if (got.blue !== want.blue)             diff = {diff, " blue"};
         if (got.last_byte !== want.last_byte)   diff = {diff, " last_of_byte"};
         if (got.last_frame !== want.last_frame) diff = {diff, " last_of_frame"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: mismatch on%s", $realtime, diff);
               $display("   expected %s", image(want));
               $display("   actual   %s", image(got));
            end
         end
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [1:0]            csr_write_data   = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_screen_byte  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [X_W-1:0]        rsp_pixel_x;
   logic [ROW_W-1:0]      rsp_pixel_row;
   logic [ADDR_W-1:0]     rsp_source_address;
   logic [PEN_W-1:0]      rsp_pen_index;
   logic [LEVEL_W-1:0]    rsp_red;
   logic [LEVEL_W-1:0]    rsp_green;
   logic [LEVEL_W-1:0]    rsp_blue;
   logic                  rsp_last_of_byte;
   logic                  rsp_last_of_frame;

   int                    hold_requests = 0;
   int                    send_idle     = 0;
   int                    recv_idle     = 0;
   pixel_scoreboard       sb            = new();

   interleaved_vram_pixel_decoder_top uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_screen_byte    (req_screen_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_source_address (rsp_source_address),
      .rsp_pen_index      (rsp_pen_index),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_last_of_byte   (rsp_last_of_byte),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

   always #5 clock = ~clock;

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_word(req_screen_byte);
         if (rsp_valid && rsp_ready)
            sb.check_pixel('{rsp_pixel_x, rsp_pixel_row, rsp_source_address,
                             rsp_pen_index, rsp_red, rsp_green, rsp_blue,
                             rsp_last_of_byte, rsp_last_of_frame});
      end
   end

   // pixel receiver: random stalls, plus a long hold-off on each request
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // run limit
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // offer one word, with an optional idle gap first
   task automatic send_word(input logic [7:0] value);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_screen_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every pixel has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the monitor note a word taken at the current edge
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_mode(value);
      csr_write_enable <= 1'b0;
   endtask

   // random words, with a fresh display mode every 30 words
   task automatic run_random(input int words);
      for (int i = 0; i < words; i++) begin
         if (i % 30 == 0) begin
            wait_drained();
            write_mode(2'($urandom_range(0, 3)));
         end
         send_word(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [7:0] pen4_words [4];
      logic [7:0] pen2_words [4];
      logic [3:0] lo_pen;
      logic [3:0] hi_pen;

      pen4_words = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
      pen2_words = '{8'h00, 8'hFF, 8'h55, 8'h80};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset mode first, all four pens
      foreach (pen4_words[i]) send_word(pen4_words[i]);
      wait_drained();
      // 16-color mode: two pens per word, all sixteen pens in order
      write_mode(MODE_PEN16);
      for (int k = 0; k < 8; k++) begin
         lo_pen = 4'(2 * k);
         hi_pen = 4'(2 * k + 1);
         send_word({lo_pen[0], hi_pen[0], lo_pen[2], hi_pen[2],
                    lo_pen[1], hi_pen[1], lo_pen[3], hi_pen[3]});
      end
      wait_drained();
      write_mode(MODE_PEN2);
      foreach (pen2_words[i]) send_word(pen2_words[i]);
      wait_drained();
      // mode code 3 behaves as the 2-color mode
      write_mode(MODE_PEN2_ALIAS);
      send_word(8'h01);
      send_word(8'hAA);

      // random phases with different idle profiles
      send_idle = 17;
      recv_idle = 83;
      run_random(100);
      send_idle = 83;
      recv_idle = 17;
      run_random(100);
      send_idle = 0;
      recv_idle = 0;
      run_random(90);

      // long receiver hold-off while words keep coming, then a full pause
      hold_requests <= hold_requests + 1;
      repeat (24) send_word(8'($urandom_range(0, 255)));
      wait_drained();
      run_random(40);

      wait_drained();
      if (sb.failures() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
